// ===== design/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg: shared constants, types and helpers for the face normal pipeline
// Holds the fixed field widths, the normalization and divider geometry and
// the square root step used by the pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int NORM_W          = 16;
	localparam int GIVEN_W         = 48;
	localparam int COLOR_W         = 24;
	localparam int BEATS           = 3;

	// Scaled magnitudes are normalized into [2^29, 2^30).
	localparam int MAG_W   = 30;
	localparam int MAG_TOP = 29;
	localparam int Q14_SH  = 14;

	// Integer square root, two result bits per pipeline stage.
	localparam int SQ_SRC_W   = 64;
	localparam int SQ_PAIRS   = SQ_SRC_W / 2;
	localparam int SQ_PER_STG = 2;
	localparam int SQ_STAGES  = SQ_PAIRS / SQ_PER_STG;
	localparam int SQ_REM_W   = 35;
	localparam int SQ_ROOT_W  = 32;
	localparam int LEN_W      = 31;

	// Restoring divider, two quotient bits per pipeline stage.
	localparam int DIV_STEPS   = 16;
	localparam int DIV_PER_STG = 2;
	localparam int DIV_STAGES  = DIV_STEPS / DIV_PER_STG;
	localparam int DIV_W       = 47;

	typedef struct packed {
		logic [SQ_REM_W-1:0]  rem;
		logic [SQ_ROOT_W-1:0] root;
	} sq_state_t;

	// One digit of the shift-in integer square root.
	function automatic sq_state_t sqrt_step(sq_state_t st, logic [1:0] pair);
		sq_state_t            nx;
		logic [SQ_REM_W-1:0]  r2;
		logic [SQ_REM_W-1:0]  tr;
		r2 = {st.rem[SQ_REM_W-3:0], pair};
		tr = {1'b0, st.root, 2'b01};
		if (r2 >= tr) begin
			nx.rem  = r2 - tr;
			nx.root = {st.root[SQ_ROOT_W-2:0], 1'b1};
		end else begin
			nx.rem  = r2;
			nx.root = {st.root[SQ_ROOT_W-2:0], 1'b0};
		end
		return nx;
	endfunction

endpackage

// ===== design/tfn_in_if.sv =====
// ----------------------------------------------------------------------------
// tfn_in_if: triangle input channel
// Valid/ready channel carrying three vertices, an optional normal and color.
// ----------------------------------------------------------------------------
interface tfn_in_if #(
	parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
);
	logic                              valid;
	logic                              ready;
	logic signed [COORD_WIDTH-1:0]     vert_a_x;
	logic signed [COORD_WIDTH-1:0]     vert_a_y;
	logic signed [COORD_WIDTH-1:0]     vert_a_z;
	logic signed [COORD_WIDTH-1:0]     vert_b_x;
	logic signed [COORD_WIDTH-1:0]     vert_b_y;
	logic signed [COORD_WIDTH-1:0]     vert_b_z;
	logic signed [COORD_WIDTH-1:0]     vert_c_x;
	logic signed [COORD_WIDTH-1:0]     vert_c_y;
	logic signed [COORD_WIDTH-1:0]     vert_c_z;
	logic [tfn_pkg::GIVEN_W-1:0]       given_normal;
	logic [tfn_pkg::COLOR_W-1:0]       color_in;

	modport source (
		output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
		       vert_c_x, vert_c_y, vert_c_z, given_normal, color_in,
		input  ready
	);
	modport sink (
		input  valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
		       vert_c_x, vert_c_y, vert_c_z, given_normal, color_in,
		output ready
	);
endinterface

// ===== design/tfn_out_if.sv =====
// ----------------------------------------------------------------------------
// tfn_out_if: vertex output channel
// Valid/ready channel carrying one emitted vertex with its face normal.
// ----------------------------------------------------------------------------
interface tfn_out_if #(
	parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
);
	logic                              valid;
	logic                              ready;
	logic signed [COORD_WIDTH-1:0]     pos_x;
	logic signed [COORD_WIDTH-1:0]     pos_y;
	logic signed [COORD_WIDTH-1:0]     pos_z;
	logic signed [tfn_pkg::NORM_W-1:0] norm_x;
	logic signed [tfn_pkg::NORM_W-1:0] norm_y;
	logic signed [tfn_pkg::NORM_W-1:0] norm_z;
	logic [tfn_pkg::COLOR_W-1:0]       color;
	logic                              last_vertex;

	modport source (
		output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, color, last_vertex,
		input  ready
	);
	modport sink (
		input  valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, color, last_vertex,
		output ready
	);
endinterface

// ===== design/triangle_face_normal.sv =====
// An accepted triangle passes through the 34 stages of the arithmetic pipeline, and
// the output stage then sends it as three vertex beats, holding the pipeline until the last
// beat is taken; while not held, the pipeline takes a new triangle every cycle.
// Reset (arst_n low, asynchronous) clears all stage valid bits and the beat counter;
// data registers are not reset.
// ----------------------------------------------------------------------------
// triangle_face_normal: flat-shaded triangle emitter with automatic normal
// Computes the unit face normal (b-a)x(c-a) in Q1.14 unless one is given,
// faces it away from the origin and emits the three vertices as beats.
// ----------------------------------------------------------------------------
module triangle_face_normal #(
	parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tfn_in_if.sink     in_tri,
	tfn_out_if.source  out_vtx
);

	localparam int W     = COORD_WIDTH;
	// Edges wider than 25 bits lose their low bits so the products stay narrow.
	localparam int SH    = (W > 24) ? W - 24 : 0;
	localparam int EW    = W + 1 - SH;
	localparam int PW    = 2 * EW;
	localparam int NW    = 2 * EW + 1;
	localparam int MW    = 2 * EW;
	localparam int PSW   = $clog2(MW);
	localparam int SW    = W + 2;
	localparam int PRW   = tfn_pkg::NORM_W + SW;
	localparam int DTW   = PRW + 2;
	localparam int NRW   = tfn_pkg::NORM_W;
	localparam int MG    = tfn_pkg::MAG_W;
	localparam int SQS   = tfn_pkg::SQ_STAGES;
	localparam int DVS   = tfn_pkg::DIV_STAGES;

	// Stage numbering along the pipeline.
	localparam int ST_S   = 7;
	localparam int ST_N   = ST_S + SQS + 1;
	localparam int ST_DOT = ST_N + DVS + 1;
	localparam int NST    = ST_DOT + 1;
	localparam logic [1:0] LAST_BEAT = 2'(tfn_pkg::BEATS - 1);

	// Side data that rides along with each triangle.
	typedef struct packed {
		logic [8:0][W-1:0]              pos;
		logic [tfn_pkg::GIVEN_W-1:0]    given;
		logic [tfn_pkg::COLOR_W-1:0]    color;
		logic [2:0][SW-1:0]             vsum;
		logic [2:0]                     nneg;
		logic                           zero;
	} car_t;

	car_t        cr [1:NST];
	logic [NST:1] v_q;
	logic        adv;
	logic [1:0]  beat_q;

	// The whole pipeline moves together; it only stops when the output stage
	// still has beats of its triangle to deliver.
	assign adv          = !v_q[NST] || (out_vtx.ready && beat_q == LAST_BEAT);
	assign in_tri.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[NST-1:1], in_tri.valid};
		end
	end

	// ---------------- Stage 1: edge vectors and vertex sum ----------------
	logic signed [W-1:0]  ca [3];
	logic signed [W-1:0]  cb [3];
	logic signed [W-1:0]  cc [3];
	logic signed [EW-1:0] u_d [3];
	logic signed [EW-1:0] v_d [3];
	logic signed [EW-1:0] u_s1 [3];
	logic signed [EW-1:0] v_s1 [3];
	car_t                 cr_in;

	always_comb begin
		logic signed [W:0]    du;
		logic signed [W:0]    dv;
		logic [W:0]           mu;
		logic [W:0]           mv;
		logic signed [EW-1:0] eu;
		logic signed [EW-1:0] ev;
		ca[0] = in_tri.vert_a_x; ca[1] = in_tri.vert_a_y; ca[2] = in_tri.vert_a_z;
		cb[0] = in_tri.vert_b_x; cb[1] = in_tri.vert_b_y; cb[2] = in_tri.vert_b_z;
		cc[0] = in_tri.vert_c_x; cc[1] = in_tri.vert_c_y; cc[2] = in_tri.vert_c_z;
		cr_in.given = in_tri.given_normal;
		cr_in.color = in_tri.color_in;
		cr_in.nneg  = '0;
		cr_in.zero  = 1'b0;
		for (int i = 0; i < 3; i++) begin
			du = (W+1)'(cb[i]) - (W+1)'(ca[i]);
			dv = (W+1)'(cc[i]) - (W+1)'(ca[i]);
			// Truncate the magnitude toward zero and keep the sign.
			mu = du[W] ? -du : du;
			mv = dv[W] ? -dv : dv;
			mu = mu >> SH;
			mv = mv >> SH;
			eu = EW'(mu);
			ev = EW'(mv);
			u_d[i] = du[W] ? -eu : eu;
			v_d[i] = dv[W] ? -ev : ev;
			cr_in.pos[i]     = ca[i];
			cr_in.pos[3 + i] = cb[i];
			cr_in.pos[6 + i] = cc[i];
			cr_in.vsum[i]    = SW'(ca[i]) + SW'(cb[i]) + SW'(cc[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cr[1] <= cr_in;
			for (int i = 0; i < 3; i++) begin
				u_s1[i] <= u_d[i];
				v_s1[i] <= v_d[i];
			end
		end
	end

	// ---------------- Stage 2: the six partial products ----------------
	logic signed [PW-1:0] p_s2 [6];

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2[0] <= u_s1[1] * v_s1[2];
			p_s2[1] <= u_s1[2] * v_s1[1];
			p_s2[2] <= u_s1[2] * v_s1[0];
			p_s2[3] <= u_s1[0] * v_s1[2];
			p_s2[4] <= u_s1[0] * v_s1[1];
			p_s2[5] <= u_s1[1] * v_s1[0];
		end
	end

	// ---------------- Stage 3: cross product, split into sign and magnitude ----------------
	logic signed [NW-1:0] n_c [3];
	logic [2:0]           nneg_c;
	logic [MW-1:0]        mag_s3 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n_c[i]    = NW'(p_s2[2*i]) - NW'(p_s2[2*i + 1]);
			nneg_c[i] = n_c[i][NW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				mag_s3[i] <= MW'(n_c[i][NW-1] ? -n_c[i] : n_c[i]);
			end
		end
	end

	// ---------------- Stage 4: largest magnitude and its leading one ----------------
	logic [MW-1:0]  mx_c;
	logic [PSW-1:0] lead_c;
	logic           zero_c;
	logic [MW-1:0]  mag_s4 [3];
	logic [PSW-1:0] lead_s4;

	always_comb begin
		mx_c = mag_s3[0];
		if (mag_s3[1] > mx_c) mx_c = mag_s3[1];
		if (mag_s3[2] > mx_c) mx_c = mag_s3[2];
		zero_c = (mx_c == '0);
		lead_c = '0;
		for (int b = 0; b < MW; b++) begin
			if (mx_c[b]) lead_c = PSW'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lead_s4 <= lead_c;
			for (int i = 0; i < 3; i++) mag_s4[i] <= mag_s3[i];
		end
	end

	// ---------------- Stage 5: shift so the largest lands in [2^29, 2^30) ----------------
	logic [MG-1:0] m_s5 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				m_s5[i] <= MG'({mag_s4[i], {tfn_pkg::MAG_TOP{1'b0}}} >> lead_s4);
			end
		end
	end

	// ---------------- Stages 6 and 7: squares and their sum ----------------
	logic [2*MG-1:0] sq_s6 [3];
	logic [MG-1:0]   m_s6 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= m_s5[i] * m_s5[i];
				m_s6[i]  <= m_s5[i];
			end
		end
	end

	logic [tfn_pkg::SQ_SRC_W-1:0] sq_src [0:SQS];
	tfn_pkg::sq_state_t           sq_st  [0:SQS];
	logic [2:0][MG-1:0]           sq_m   [0:SQS];

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_src[0] <= tfn_pkg::SQ_SRC_W'(sq_s6[0]) + tfn_pkg::SQ_SRC_W'(sq_s6[1])
			           + tfn_pkg::SQ_SRC_W'(sq_s6[2]);
			sq_st[0]  <= '0;
			for (int i = 0; i < 3; i++) sq_m[0][i] <= m_s6[i];
		end
	end

	// ---------------- Square root: two digits per stage ----------------
	for (genvar t = 1; t <= SQS; t++) begin : g_sqrt
		tfn_pkg::sq_state_t           st_d;
		logic [tfn_pkg::SQ_SRC_W-1:0] src_d;

		always_comb begin
			st_d  = sq_st[t-1];
			src_d = sq_src[t-1];
			for (int s = 0; s < tfn_pkg::SQ_PER_STG; s++) begin
				st_d  = tfn_pkg::sqrt_step(st_d, src_d[tfn_pkg::SQ_SRC_W-1 -: 2]);
				src_d = {src_d[tfn_pkg::SQ_SRC_W-3:0], 2'b00};
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_st[t]  <= st_d;
				sq_src[t] <= src_d;
				sq_m[t]   <= sq_m[t-1];
			end
		end
	end

	// ---------------- Divider: numerator with rounding half, then two bits per stage ----------------
	logic [2:0][tfn_pkg::DIV_W-1:0]  dv_rem [0:DVS];
	logic [2:0][tfn_pkg::NORM_W-1:0] dv_q   [0:DVS];
	logic [tfn_pkg::LEN_W-1:0]       dv_len [0:DVS];
	logic [tfn_pkg::LEN_W-1:0]       len_c;

	assign len_c = sq_st[SQS].root[tfn_pkg::LEN_W-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_len[0] <= len_c;
			dv_q[0]   <= '0;
			for (int i = 0; i < 3; i++) begin
				dv_rem[0][i] <= tfn_pkg::DIV_W'({sq_m[SQS][i], {tfn_pkg::Q14_SH{1'b0}}})
				              + tfn_pkg::DIV_W'(len_c[tfn_pkg::LEN_W-1:1]);
			end
		end
	end

	for (genvar j = 1; j <= DVS; j++) begin : g_div
		logic [2:0][tfn_pkg::DIV_W-1:0]  rem_d;
		logic [2:0][tfn_pkg::NORM_W-1:0] q_d;

		always_comb begin
			logic [tfn_pkg::DIV_W-1:0] den;
			int                        bi;
			rem_d = dv_rem[j-1];
			q_d   = dv_q[j-1];
			for (int s = 0; s < tfn_pkg::DIV_PER_STG; s++) begin
				bi  = tfn_pkg::DIV_STEPS - 1 - (j - 1) * tfn_pkg::DIV_PER_STG - s;
				den = tfn_pkg::DIV_W'(dv_len[j-1]) << bi;
				for (int i = 0; i < 3; i++) begin
					if (rem_d[i] >= den) begin
						rem_d[i]    = rem_d[i] - den;
						q_d[i][bi] = 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem[j] <= rem_d;
				dv_q[j]   <= q_d;
				dv_len[j] <= dv_len[j-1];
			end
		end
	end

	// ---------------- Dot product with the vertex sum ----------------
	logic signed [NRW-1:0] ns_c    [3];
	logic signed [NRW-1:0] ns_dot  [3];
	logic signed [PRW-1:0] prd_dot [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ns_c[i] = cr[ST_DOT-1].nneg[i] ? -$signed(dv_q[DVS][i]) : $signed(dv_q[DVS][i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				ns_dot[i]  <= ns_c[i];
				prd_dot[i] <= PRW'(ns_c[i]) * PRW'($signed(cr[ST_DOT-1].vsum[i]));
			end
		end
	end

	// ---------------- Final stage: orientation and normal selection ----------------
	logic signed [DTW-1:0] dot_c;
	logic signed [NRW-1:0] nrm_c   [3];
	logic signed [NRW-1:0] nrm_out [3];

	always_comb begin
		dot_c = DTW'(prd_dot[0]) + DTW'(prd_dot[1]) + DTW'(prd_dot[2]);
		for (int i = 0; i < 3; i++) begin
			if (cr[ST_DOT].given != '0) begin
				// A supplied normal passes through untouched.
				nrm_c[i] = cr[ST_DOT].given[NRW*i +: NRW];
			end else if (cr[ST_DOT].zero) begin
				nrm_c[i] = '0;
			end else if (dot_c < 0) begin
				nrm_c[i] = -ns_dot[i];
			end else begin
				nrm_c[i] = ns_dot[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) nrm_out[i] <= nrm_c[i];
		end
	end

	// ---------------- Side data travels stage by stage ----------------
	for (genvar k = 2; k <= NST; k++) begin : g_car
		car_t cr_d;

		always_comb begin
			cr_d = cr[k-1];
			if (k == 3) cr_d.nneg = nneg_c;
			if (k == 4) cr_d.zero = zero_c;
		end

		always_ff @(posedge clk) begin
			if (adv) cr[k] <= cr_d;
		end
	end

	// ---------------- Output stage: three vertex beats per triangle ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= '0;
		end else if (out_vtx.valid && out_vtx.ready) begin
			beat_q <= (beat_q == LAST_BEAT) ? 2'd0 : beat_q + 2'd1;
		end
	end

	always_comb begin
		out_vtx.valid       = v_q[NST];
		out_vtx.norm_x      = nrm_out[0];
		out_vtx.norm_y      = nrm_out[1];
		out_vtx.norm_z      = nrm_out[2];
		out_vtx.color       = cr[NST].color;
		out_vtx.last_vertex = (beat_q == LAST_BEAT);
		case (beat_q)
			2'd0: begin
				out_vtx.pos_x = cr[NST].pos[0];
				out_vtx.pos_y = cr[NST].pos[1];
				out_vtx.pos_z = cr[NST].pos[2];
			end
			2'd1: begin
				out_vtx.pos_x = cr[NST].pos[3];
				out_vtx.pos_y = cr[NST].pos[4];
				out_vtx.pos_z = cr[NST].pos[5];
			end
			default: begin
				out_vtx.pos_x = cr[NST].pos[6];
				out_vtx.pos_y = cr[NST].pos[7];
				out_vtx.pos_z = cr[NST].pos[8];
			end
		endcase
	end

	// ---------------- Assertions ----------------
	// The beat counter only moves while a triangle sits in the output stage.
	a_beat_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!v_q[NST] |-> beat_q == 2'd0)
		else $error("beat counter nonzero with empty output stage");

	// A triangle is not dropped before its third beat has gone out.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_vtx.valid && out_vtx.ready && !out_vtx.last_vertex |=> out_vtx.valid)
		else $error("triangle left output stage before its last beat");

	// Each component of a computed normal stays within [-1.0, 1.0] in Q1.14.
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NST] && cr[NST].given == '0 |->
			nrm_out[0] <= 16'sd16384 && nrm_out[0] >= -16'sd16384 &&
			nrm_out[1] <= 16'sd16384 && nrm_out[1] >= -16'sd16384 &&
			nrm_out[2] <= 16'sd16384 && nrm_out[2] >= -16'sd16384)
		else $error("computed normal component out of range");

endmodule

// ===== sim/triangle_face_normal_checker.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal_checker: scoreboard for the face normal emitter
// Watches both channels, predicts the three vertex beats of every accepted
// triangle and compares each accepted output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module triangle_face_normal_checker (
	input  logic      clk,
	input  logic      arst_n,
	tfn_in_if         in_tri,
	tfn_out_if        out_vtx,
	output int        errors,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] px, py, pz, nx, ny, nz;
		logic [23:0] col;
		logic        last;
	} vtx_beat_t;

	vtx_beat_t vertex_queue[$];

	function automatic longint unsigned root64(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Unit normal in Q1.14 of (b-a)x(c-a), faced away from the origin.
	function automatic void unit_normal(input longint p[3][3], output longint nrm[3]);
		longint u[3], v[3], n[3], dot;
		longint unsigned m[3], mx, s, len, q;
		for (int i = 0; i < 3; i++) begin
			u[i] = p[1][i] - p[0][i];
			v[i] = p[2][i] - p[0][i];
		end
		n[0] = u[1] * v[2] - u[2] * v[1];
		n[1] = u[2] * v[0] - u[0] * v[2];
		n[2] = u[0] * v[1] - u[1] * v[0];
		for (int i = 0; i < 3; i++) m[i] = (n[i] < 0) ? -n[i] : n[i];
		mx = m[0];
		if (m[1] > mx) mx = m[1];
		if (m[2] > mx) mx = m[2];
		if (mx == 0) begin
			nrm[0] = 0; nrm[1] = 0; nrm[2] = 0;
			return;
		end
		while (mx >= (64'd1 << 30)) begin
			mx = mx >> 1;
			for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx = mx << 1;
			for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
		end
		s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		len = root64(s);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * 16384 + len / 2) / len;
			nrm[i] = (n[i] < 0) ? -longint'(q) : longint'(q);
		end
		dot = 0;
		for (int i = 0; i < 3; i++) dot += nrm[i] * (p[0][i] + p[1][i] + p[2][i]);
		if (dot < 0) for (int i = 0; i < 3; i++) nrm[i] = -nrm[i];
	endfunction

	task automatic predict_triangle();
		longint p[3][3], nrm[3];
		vtx_beat_t vb;
		p[0][0] = in_tri.vert_a_x; p[0][1] = in_tri.vert_a_y; p[0][2] = in_tri.vert_a_z;
		p[1][0] = in_tri.vert_b_x; p[1][1] = in_tri.vert_b_y; p[1][2] = in_tri.vert_b_z;
		p[2][0] = in_tri.vert_c_x; p[2][1] = in_tri.vert_c_y; p[2][2] = in_tri.vert_c_z;
		if (in_tri.given_normal != '0) begin
			for (int i = 0; i < 3; i++) nrm[i] = longint'(in_tri.given_normal[16*i +: 16]);
		end else begin
			unit_normal(p, nrm);
		end
		for (int k = 0; k < 3; k++) begin
			vb.px = 16'(p[k][0]); vb.py = 16'(p[k][1]); vb.pz = 16'(p[k][2]);
			vb.nx = 16'(nrm[0]); vb.ny = 16'(nrm[1]); vb.nz = 16'(nrm[2]);
			vb.col = in_tri.color_in;
			vb.last = (k == 2);
			vertex_queue.push_back(vb);
		end
	endtask

	initial errors = 0;

	always @(posedge clk) begin
		vtx_beat_t got, want;
		if (arst_n) begin
			if (in_tri.valid && in_tri.ready) predict_triangle();
			if (out_vtx.valid && out_vtx.ready) begin
				got = {out_vtx.pos_x, out_vtx.pos_y, out_vtx.pos_z, out_vtx.norm_x,
					out_vtx.norm_y, out_vtx.norm_z, out_vtx.color, out_vtx.last_vertex};
				if (vertex_queue.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected vertex beat %h", got);
				end else begin
					want = vertex_queue.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10) $display("vertex mismatch: expected %h actual %h", want, got);
					end
				end
			end
		end
		pending <= vertex_queue.size();
	end
endmodule

// ===== sim/triangle_face_normal_tb.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal_tb: stimulus and verdict for the face normal emitter
// Drives directed and random triangles with random idling on both sides,
// leaves checking to the scoreboard and reports the outcome.
// ----------------------------------------------------------------------------
module triangle_face_normal_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int   errors, pending;
	int   src_idle, snk_idle;   // idle percentages of sender and receiver
	bit   hold_off;             // long receiver stall in progress
	int   quiet_cycles;

	tfn_in_if  in_tri();
	tfn_out_if out_vtx();

	triangle_face_normal DUT (.clk(clk), .arst_n(arst_n), .in_tri(in_tri), .out_vtx(out_vtx));
	triangle_face_normal_checker u_checker (.clk(clk), .arst_n(arst_n), .in_tri(in_tri),
		.out_vtx(out_vtx), .errors(errors), .pending(pending));

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: random ready, unless a long hold-off is requested.
	initial out_vtx.ready = 1'b0;
	always @(posedge clk) begin
		out_vtx.ready <= !hold_off && ($urandom_range(99) >= snk_idle);
	end

	// Watchdog: the run ends if no beat moves on either side for too long.
	always @(posedge clk) begin
		if ((in_tri.valid && in_tri.ready) || (out_vtx.valid && out_vtx.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Places one triangle on the channel and waits for its acceptance.
	task automatic send_triangle(input logic [15:0] c[9], input logic [47:0] gn,
		input logic [23:0] col);
		while ($urandom_range(99) < src_idle) begin
			in_tri.valid <= 1'b0;
			@(posedge clk);
		end
		in_tri.valid        <= 1'b1;
		in_tri.vert_a_x     <= c[0]; in_tri.vert_a_y <= c[1]; in_tri.vert_a_z <= c[2];
		in_tri.vert_b_x     <= c[3]; in_tri.vert_b_y <= c[4]; in_tri.vert_b_z <= c[5];
		in_tri.vert_c_x     <= c[6]; in_tri.vert_c_y <= c[7]; in_tri.vert_c_z <= c[8];
		in_tri.given_normal <= gn;
		in_tri.color_in     <= col;
		do @(posedge clk); while (!in_tri.ready);
	endtask

	// Random triangle: mostly computed normals, some given, some degenerate,
	// with coordinate magnitudes ranging from tiny to full scale.
	task automatic random_triangle();
		logic [15:0]        c[9];
		logic [47:0]        gn;
		logic signed [15:0] rv;
		int sh, kind;
		sh = $urandom_range(15);
		kind = $urandom_range(9);
		for (int i = 0; i < 9; i++) begin
			rv = 16'($urandom());
			if ($urandom_range(3) == 0)
				c[i] = rv;
			else
				c[i] = rv >>> sh;
		end
		if (kind == 0) begin
			c[3] = c[0]; c[4] = c[1]; c[5] = c[2];
		end
		gn = (kind == 1) ? 48'({$urandom(), $urandom()}) : 48'd0;
		send_triangle(c, gn, 24'($urandom()));
	endtask

	task automatic drain();
		in_tri.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		logic [15:0] c[9];
		in_tri.valid <= 1'b0;
		in_tri.vert_a_x <= '0; in_tri.vert_a_y <= '0; in_tri.vert_a_z <= '0;
		in_tri.vert_b_x <= '0; in_tri.vert_b_y <= '0; in_tri.vert_b_z <= '0;
		in_tri.vert_c_x <= '0; in_tri.vert_c_y <= '0; in_tri.vert_c_z <= '0;
		in_tri.given_normal <= '0; in_tri.color_in <= '0;
		hold_off = 1'b0; src_idle = 24; snk_idle = 61; quiet_cycles = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: unit axes, negative orientation, full-scale corners,
		// degenerate triangles and given normals including out-of-range ones.
		c = '{0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100, 0};
		send_triangle(c, 48'd0, 24'h0000ff);
		c = '{0, 0, 0, 0, 16'h0100, 0, 16'h0100, 0, 0};
		send_triangle(c, 48'd0, 24'hffffff);
		c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
			16'h8000, 16'h7fff, 16'h8000};
		send_triangle(c, 48'd0, 24'h123456);
		c = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
			16'h7fff, 16'h7fff, 16'h8000};
		send_triangle(c, 48'd0, 24'h000000);
		c = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
			16'h0001, 16'hffff, 16'h0000};
		send_triangle(c, 48'd0, 24'habcdef);
		c = '{1, 2, 3, 1, 2, 3, 5, 6, 7};
		send_triangle(c, 48'd0, 24'h00ff00);
		c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_triangle(c, 48'd0, 24'hff0000);
		c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
		send_triangle(c, 48'd0, 24'h0f0f0f);
		send_triangle(c, 48'hffff_ffff_ffff, 24'h555555);
		send_triangle(c, 48'h0000_0000_0001, 24'haaaaaa);
		send_triangle(c, 48'h8000_7fff_c000, 24'h777777);
		send_triangle(c, 48'h4000_0000_0000, 24'h888888);
		drain();

		// Long receiver hold-off while the sender keeps offering.
		hold_off = 1'b1;
		fork
			repeat (30) random_triangle();
			begin
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
		join
		drain();

		for (int i = 0; i < 170; i++) random_triangle();
		drain();
		src_idle = 61; snk_idle = 24;
		for (int i = 0; i < 150; i++) random_triangle();
		drain();
		src_idle = 0; snk_idle = 0;
		for (int i = 0; i < 150; i++) random_triangle();
		drain();

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ===== triangle_face_normal.f =====
design/tfn_pkg.sv
design/tfn_in_if.sv
design/tfn_out_if.sv
design/triangle_face_normal.sv
sim/triangle_face_normal_checker.sv
sim/triangle_face_normal_tb.sv
